>>> sv/hbl_pkg.sv
// ----------------------------------------------------------------------------
// hbl_pkg: shared types and constants for the height map lookup
// Field widths, register codes and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package hbl_pkg;

    // default sizes of the grid store
    localparam int DEF_MAX_POINTS  = 512;
    localparam int DEF_MAX_COLUMNS = 64;

    // field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int POS_W      = 32;
    localparam int HGT_W      = 16;
    localparam int INV_W      = 26;
    localparam int COLS_W     = 7;
    localparam int ROWS_W     = 10;
    localparam int COL_IDX_W  = 6;
    localparam int ROW_IDX_W  = 9;
    localparam int FRAC_W     = 16;

    // derived datapath widths
    localparam int ADDR_W  = 18;
    localparam int PROD_W  = POS_W + INV_W;
    localparam int KRAW_W  = PROD_W - FRAC_W;
    localparam int KIDX_W  = ROWS_W + FRAC_W;
    localparam int WGT_W   = FRAC_W + 1;
    localparam int WPROD_W = 2 * WGT_W;
    localparam int HPROD_W = HGT_W + WPROD_W + 1;
    localparam int ACC_W   = HPROD_W;
    localparam int RQ_W    = ACC_W - 2 * FRAC_W;

    localparam logic [WGT_W-1:0] WGT_ONE    = WGT_W'(1) << FRAC_W;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (2 * FRAC_W - 1);

    // item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_ENABLE = 3'd0,
        REG_ORIGIN0    = 3'd1,
        REG_ORIGIN1    = 3'd2,
        REG_INV_PITCH0 = 3'd3,
        REG_INV_PITCH1 = 3'd4,
        REG_COLUMNS    = 3'd5,
        REG_ROWS       = 3'd6
    } cfg_reg_t;

    // configuration as seen by the datapath, grid size already limited
    typedef struct packed {
        logic              map_enable;
        logic [POS_W-1:0]  origin0;
        logic [POS_W-1:0]  origin1;
        logic [INV_W-1:0]  inv_pitch0;
        logic [INV_W-1:0]  inv_pitch1;
        logic [COLS_W-1:0] ncol;
        logic [ROWS_W-1:0] nrow;
    } cfg_t;

    // input word payload
    typedef struct packed {
        logic                 mode;
        logic [COL_IDX_W-1:0] column;
        logic [ROW_IDX_W-1:0] row_index;
        logic [HGT_W-1:0]     height_in;
        logic [POS_W-1:0]     pos0;
        logic [POS_W-1:0]     pos1;
    } req_word_t;

    // controller to datapath
    typedef struct packed {
        logic       clear;
        logic       load_in;
        logic       offs;
        logic       write;
        logic       mul0;
        logic       mul1;
        logic       clamp1;
        logic       base;
        logic       acc_clr;
        logic       rd_go;
        logic [1:0] corner;
        logic       mac;
        logic       acc;
        logic       load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic is_query;
        logic map_enable;
    } st_t;

endpackage

>>> sv/hbl_if.sv
// ----------------------------------------------------------------------------
// hbl_if: stream channels of the height map lookup
// Request channel carries write and query words, response channel the answers.
// ----------------------------------------------------------------------------
interface hbl_req_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [5:0]         column;
    logic [8:0]         row_index;
    logic signed [15:0] height_in;
    logic signed [31:0] pos0;
    logic signed [31:0] pos1;

    modport source (output valid, mode, column, row_index, height_in, pos0, pos1,
                    input ready);
    modport sink   (input valid, mode, column, row_index, height_in, pos0, pos1,
                    output ready);
endinterface

interface hbl_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] height_out;
    logic               accepted;

    modport source (output valid, height_out, accepted, input ready);
    modport sink   (input valid, height_out, accepted, output ready);
endinterface

>>> sv/hbl_cfg.sv
// ----------------------------------------------------------------------------
// hbl_cfg: configuration registers
// Holds the programmed grid geometry and limits the grid size for use.
// ----------------------------------------------------------------------------
module hbl_cfg #(
    parameter int MAX_COLUMNS = hbl_pkg::DEF_MAX_COLUMNS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hbl_pkg::CFG_DATA_W-1:0] cfg_data,
    output hbl_pkg::cfg_t                  cfg
);
    import hbl_pkg::*;

    logic              map_enable_reg;
    logic [POS_W-1:0]  origin0_reg;
    logic [POS_W-1:0]  origin1_reg;
    logic [INV_W-1:0]  inv_pitch0_reg;
    logic [INV_W-1:0]  inv_pitch1_reg;
    logic [COLS_W-1:0] columns_reg;
    logic [ROWS_W-1:0] rows_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_enable_reg <= 1'b0;
            origin0_reg    <= '0;
            origin1_reg    <= '0;
            inv_pitch0_reg <= INV_W'(65536);
            inv_pitch1_reg <= INV_W'(65536);
            columns_reg    <= COLS_W'(2);
            rows_reg       <= ROWS_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MAP_ENABLE: map_enable_reg <= cfg_data[0];
                REG_ORIGIN0:    origin0_reg    <= cfg_data[POS_W-1:0];
                REG_ORIGIN1:    origin1_reg    <= cfg_data[POS_W-1:0];
                REG_INV_PITCH0: inv_pitch0_reg <= cfg_data[INV_W-1:0];
                REG_INV_PITCH1: inv_pitch1_reg <= cfg_data[INV_W-1:0];
                REG_COLUMNS:    columns_reg    <= cfg_data[COLS_W-1:0];
                REG_ROWS:       rows_reg       <= cfg_data[ROWS_W-1:0];
                default:        ;
            endcase
        end
    end

    // grid size limited to at least two points and the column capacity
    always_comb
    begin
        cfg.map_enable = map_enable_reg;
        cfg.origin0    = origin0_reg;
        cfg.origin1    = origin1_reg;
        cfg.inv_pitch0 = inv_pitch0_reg;
        cfg.inv_pitch1 = inv_pitch1_reg;
        if (columns_reg < COLS_W'(2))
            cfg.ncol = COLS_W'(2);
        else if (int'(columns_reg) > MAX_COLUMNS)
            cfg.ncol = COLS_W'(MAX_COLUMNS);
        else
            cfg.ncol = columns_reg;
        cfg.nrow = (rows_reg < ROWS_W'(2)) ? ROWS_W'(2) : rows_reg;
    end

endmodule

>>> sv/hbl_datapath.sv
// ----------------------------------------------------------------------------
// hbl_datapath: grid store and interpolation arithmetic
// Height memory, cell index multiply and clamp, corner weights, multiply
// accumulate over the four neighbours and rounding of the answer.
// ----------------------------------------------------------------------------
module hbl_datapath #(
    parameter int MAX_POINTS = hbl_pkg::DEF_MAX_POINTS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hbl_pkg::cfg_t             cfg,
    input  hbl_pkg::req_word_t        req_word,
    input  hbl_pkg::cmd_t             cmd,
    output hbl_pkg::st_t              st,
    output logic [hbl_pkg::HGT_W-1:0] height_out,
    output logic                      accepted
);
    import hbl_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    // Q10.16 index, limited to one fraction step below the last point
    function automatic logic [KIDX_W-1:0] clamp_index(input logic [PROD_W-1:0] prod,
                                                      input logic [ROWS_W-1:0] n);
        logic [KIDX_W-1:0] lim;
        logic [KRAW_W-1:0] k;
        begin
            lim = {n - ROWS_W'(1), {FRAC_W{1'b0}}} - KIDX_W'(1);
            k   = prod[PROD_W-1:FRAC_W];
            if (k > KRAW_W'(lim))
                return lim;
            else
                return k[KIDX_W-1:0];
        end
    endfunction

    logic [HGT_W-1:0]         mem [MAX_POINTS];
    req_word_t                in_reg;
    logic [AW-1:0]            clr_addr_reg;
    logic                     wr_ok_reg;
    logic [POS_W-1:0]         d0_reg;
    logic [POS_W-1:0]         d1_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [KIDX_W-1:0]        k0_reg;
    logic [KIDX_W-1:0]        k1_reg;
    logic [ADDR_W-1:0]        base_reg;
    logic [WPROD_W-1:0]       weight_reg;
    logic [HGT_W-1:0]         rd_data_reg;
    logic                     rd_ok_reg;
    logic signed [HPROD_W-1:0] hprod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [HGT_W-1:0]         height_out_reg;
    logic                     accepted_reg;

    logic [POS_W:0]           diff0;
    logic [POS_W:0]           diff1;
    logic [ADDR_W-1:0]        waddr;
    logic                     waddr_ok;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [HGT_W-1:0]         mem_wdata;
    logic [ADDR_W-1:0]        rd_addr;
    logic [POS_W-1:0]         mul_a;
    logic [INV_W-1:0]         mul_b;
    logic [WGT_W-1:0]         fx;
    logic [WGT_W-1:0]         gx;
    logic [WGT_W-1:0]         fy;
    logic [WGT_W-1:0]         gy;
    logic [WGT_W-1:0]         wx;
    logic [WGT_W-1:0]         wy;
    logic signed [HGT_W-1:0]  rd_val;
    logic [ACC_W-1:0]         rsum;
    logic signed [RQ_W-1:0]   rq;
    logic [HGT_W-1:0]         rq_sat;

    localparam logic signed [RQ_W-1:0] HMAX =
        {{(RQ_W-HGT_W+1){1'b0}}, {(HGT_W-1){1'b1}}};
    localparam logic signed [RQ_W-1:0] HMIN =
        {{(RQ_W-HGT_W+1){1'b1}}, {(HGT_W-1){1'b0}}};

    // status back to the controller
    assign st.clear_last = (clr_addr_reg == AW'(MAX_POINTS - 1));
    assign st.is_query   = (in_reg.mode == MODE_QUERY);
    assign st.map_enable = cfg.map_enable;

    // offsets from the grid origin, sign extended
    assign diff0 = {in_reg.pos0[POS_W-1], in_reg.pos0} - {cfg.origin0[POS_W-1], cfg.origin0};
    assign diff1 = {in_reg.pos1[POS_W-1], in_reg.pos1} - {cfg.origin1[POS_W-1], cfg.origin1};

    // write address, row by row
    assign waddr    = ADDR_W'(in_reg.row_index) * ADDR_W'(cfg.ncol) + ADDR_W'(in_reg.column);
    assign waddr_ok = (waddr < ADDR_W'(MAX_POINTS));

    // memory port: clearing sweep or stored height
    assign mem_we    = cmd.clear | (cmd.write & waddr_ok);
    assign mem_waddr = cmd.clear ? clr_addr_reg : waddr[AW-1:0];
    assign mem_wdata = cmd.clear ? '0 : in_reg.height_in;

    // neighbour address for the current corner
    assign rd_addr = base_reg + (cmd.corner[1] ? ADDR_W'(cfg.ncol) : '0)
                   + ADDR_W'(cmd.corner[0]);

    // shared index multiplier operands
    assign mul_a = cmd.mul1 ? d1_reg : d0_reg;
    assign mul_b = cmd.mul1 ? cfg.inv_pitch1 : cfg.inv_pitch0;

    // bilinear weights from the fractions
    assign fx = {1'b0, k0_reg[FRAC_W-1:0]};
    assign fy = {1'b0, k1_reg[FRAC_W-1:0]};
    assign gx = WGT_ONE - fx;
    assign gy = WGT_ONE - fy;
    assign wx = cmd.corner[0] ? fx : gx;
    assign wy = cmd.corner[1] ? fy : gy;

    // neighbours outside the store read as zero
    assign rd_val = rd_ok_reg ? $signed(rd_data_reg) : '0;

    // round half up and saturate
    assign rsum = acc_reg + ROUND_HALF;
    assign rq   = $signed(rsum[ACC_W-1:2*FRAC_W]);
    always_comb
    begin
        if (rq > HMAX)
            rq_sat = HMAX[HGT_W-1:0];
        else if (rq < HMIN)
            rq_sat = HMIN[HGT_W-1:0];
        else
            rq_sat = rq[HGT_W-1:0];
    end

    // height memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    // clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear)
            clr_addr_reg <= clr_addr_reg + AW'(1);
    end

    // arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= req_word;
        if (cmd.write)
            wr_ok_reg <= waddr_ok;
        if (cmd.offs)
        begin
            d0_reg <= (diff0[POS_W] || diff0 == '0) ? '0 : diff0[POS_W-1:0];
            d1_reg <= (diff1[POS_W] || diff1 == '0) ? '0 : diff1[POS_W-1:0];
        end
        if (cmd.mul0 || cmd.mul1)
            prod_reg <= mul_a * mul_b;
        if (cmd.mul1)
            k0_reg <= clamp_index(prod_reg, ROWS_W'(cfg.ncol));
        if (cmd.clamp1)
            k1_reg <= clamp_index(prod_reg, cfg.nrow);
        if (cmd.base)
            base_reg <= ADDR_W'(k1_reg[KIDX_W-1:FRAC_W]) * ADDR_W'(cfg.ncol)
                      + ADDR_W'(k0_reg[KIDX_W-1:FRAC_W]);
        if (cmd.rd_go)
        begin
            weight_reg <= wx * wy;
            rd_ok_reg  <= (rd_addr < ADDR_W'(MAX_POINTS));
        end
        if (cmd.mac)
            hprod_reg <= rd_val * $signed({1'b0, weight_reg});
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (cmd.acc)
            acc_reg <= acc_reg + hprod_reg;
        if (cmd.load_out)
        begin
            height_out_reg <= (st.is_query && cfg.map_enable) ? rq_sat : '0;
            accepted_reg   <= st.is_query ? 1'b1 : wr_ok_reg;
        end
    end

    assign height_out = height_out_reg;
    assign accepted   = accepted_reg;

endmodule

>>> sv/hbl_ctrl.sv
// ----------------------------------------------------------------------------
// hbl_ctrl: sequencer of the height map lookup
// Runs the clearing sweep, takes one word at a time, steps the datapath
// through a query and owns the response valid flag.
// ----------------------------------------------------------------------------
module hbl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  hbl_pkg::st_t  st,
    output hbl_pkg::cmd_t cmd
);
    import hbl_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_START  = 9'b000000100,
        S_MUL0   = 9'b000001000,
        S_MUL1   = 9'b000010000,
        S_CLAMP1 = 9'b000100000,
        S_BASE   = 9'b001000000,
        S_READ   = 9'b010000000,
        S_FIN    = 9'b100000000
    } state_t;

    localparam int CNT_W = 3;
    localparam logic [CNT_W-1:0] CORNERS   = CNT_W'(4);
    localparam logic [CNT_W-1:0] READ_LAST = CNT_W'(5);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        if (rsp_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (st.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                cmd.offs  = 1'b1;
                cmd.write = !st.is_query;
                if (!st.is_query || !st.map_enable)
                    state_next = S_FIN;
                else
                    state_next = S_MUL0;
            end
            S_MUL0:
            begin
                cmd.mul0   = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_CLAMP1;
            end
            S_CLAMP1:
            begin
                cmd.clamp1 = 1'b1;
                state_next = S_BASE;
            end
            S_BASE:
            begin
                cmd.base    = 1'b1;
                cmd.acc_clr = 1'b1;
                cnt_next    = '0;
                state_next  = S_READ;
            end
            S_READ:
            begin
                // read, multiply and accumulate overlap by one corner each
                cmd.rd_go  = (cnt_reg < CORNERS);
                cmd.corner = cnt_reg[1:0];
                cmd.mac    = (cnt_reg >= CNT_W'(1)) && (cnt_reg <= CORNERS);
                cmd.acc    = (cnt_reg >= CNT_W'(2));
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == READ_LAST)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    // one word in flight: ready drops after a word is taken
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("word accepted while another is in flight");

    // nothing is taken before the store is cleared
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req_ready)
        else $error("word accepted during clearing sweep");

    // single memory port
    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.write, cmd.rd_go}))
        else $error("memory port used twice in one cycle");

    // accumulate follows the multiply of the same corner
    a_mac_align: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc |-> $past(cmd.mac))
        else $error("accumulate without a preceding multiply");

endmodule

>>> sv/height_map_bilinear_lookup.sv
// ----------------------------------------------------------------------------
// height_map_bilinear_lookup: bed height map with bilinear lookup
// Stores a grid of height errors and answers interpolated heights.
//
// channel   dir   handshake      payload
// req       in    valid/ready    mode, column, row_index, height_in, pos0, pos1
// rsp       out   valid/ready    height_out, accepted
// cfg       in    cfg_we         cfg_index, cfg_data
//
// A query steps from acceptance through offset, two index multiplies on one
// shared multiplier, clamp, base address, then four neighbour reads through
// the single memory port, overlapped with the weight multiply and the
// accumulate. Writes and disabled queries go from offset straight to the answer.
// After reset a clearing sweep zeroes the store, and no word is taken
// meanwhile; configuration writes go through as usual.
// A held response stalls the sequencer only when the next answer is ready.
// ----------------------------------------------------------------------------
module height_map_bilinear_lookup #(
    parameter int MAX_POINTS  = hbl_pkg::DEF_MAX_POINTS,
    parameter int MAX_COLUMNS = hbl_pkg::DEF_MAX_COLUMNS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    hbl_req_if.sink                        req,
    hbl_rsp_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [hbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hbl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hbl_pkg::*;

    cfg_t             cfg;
    req_word_t        req_word;
    cmd_t             cmd;
    st_t              st;
    logic             req_ready;
    logic             rsp_valid;
    logic [HGT_W-1:0] height_out;
    logic             accepted;

    // request payload into one word
    always_comb
    begin
        req_word.mode      = req.mode;
        req_word.column    = req.column;
        req_word.row_index = req.row_index;
        req_word.height_in = req.height_in;
        req_word.pos0      = req.pos0;
        req_word.pos1      = req.pos1;
    end

    assign req.ready      = req_ready;
    assign rsp.valid      = rsp_valid;
    assign rsp.height_out = $signed(height_out);
    assign rsp.accepted   = accepted;

    hbl_cfg #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hbl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    hbl_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req_word   (req_word),
        .cmd        (cmd),
        .st         (st),
        .height_out (height_out),
        .accepted   (accepted)
    );

endmodule
